### design/regular_polygon_vertex_generator_defines.svh
`ifndef REGULAR_POLYGON_VERTEX_GENERATOR_DEFINES_SVH
`define REGULAR_POLYGON_VERTEX_GENERATOR_DEFINES_SVH

// Same-cycle implication, checking disabled in reset.
`define RPVG_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checking disabled in reset.
`define RPVG_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/rpvg_pkg.sv
`default_nettype none
package rpvg_pkg;

    localparam int NUM_SIDES_W   = 6;
    localparam int MIN_SIDES     = 3;
    localparam int MAX_SIDES     = 63;
    localparam int DEFAULT_SIDES = 6;
    localparam int CORDIC_STEPS  = 24;
    localparam int STEP_W        = 5;

    localparam logic signed [33:0] CORDIC_GAIN = 34'sh026DD3B6A;
    localparam logic signed [33:0] ONE_Q30     = 34'sh040000000;

    typedef struct packed {
        logic signed [31:0] cos_q30;
        logic signed [31:0] sin_q30;
    } cs_t;

    // arctangent of 2^-k in units of 2^32 per turn
    function automatic logic signed [31:0] atan_turns(input logic [STEP_W-1:0] k);
        logic signed [31:0] a;
        case (k)
            5'd0:  a = 32'sh20000000;
            5'd1:  a = 32'sh12E4051E;
            5'd2:  a = 32'sh09FB385B;
            5'd3:  a = 32'sh051111D4;
            5'd4:  a = 32'sh028B0D43;
            5'd5:  a = 32'sh0145D7E1;
            5'd6:  a = 32'sh00A2F61E;
            5'd7:  a = 32'sh00517C55;
            5'd8:  a = 32'sh0028BE53;
            5'd9:  a = 32'sh00145F2F;
            5'd10: a = 32'sh000A2F98;
            5'd11: a = 32'sh000517CC;
            5'd12: a = 32'sh00028BE6;
            5'd13: a = 32'sh000145F3;
            5'd14: a = 32'sh0000A2FA;
            5'd15: a = 32'sh0000517D;
            5'd16: a = 32'sh000028BE;
            5'd17: a = 32'sh0000145F;
            5'd18: a = 32'sh00000A30;
            5'd19: a = 32'sh00000518;
            5'd20: a = 32'sh0000028C;
            5'd21: a = 32'sh00000146;
            5'd22: a = 32'sh000000A3;
            5'd23: a = 32'sh00000051;
            default: a = 32'sh0;
        endcase
        return a;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [36:0] v);
        logic [31:0] r;
        if (v[36:31] == 6'b000000 || v[36:31] == 6'b111111) begin
            r = v[31:0];
        end else if (v[36]) begin
            r = 32'h80000000;
        end else begin
            r = 32'h7FFFFFFF;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### design/regular_polygon_vertex_generator.sv
// Regular polygon vertex generator. Each request carries a centre and a pointer
// vertex (signed Q16.16) and a square-snap flag in s_tuser; the block returns
// num_sides+1 vertices, the start vertex first and the closing vertex last with
// m_tlast set. The closing vertex always lies on a multiple of 90 degrees, where
// the CORDIC iterations are skipped. A bit-serial division sets the angle step,
// then each vertex takes a phase update, the 24-step CORDIC unit, an 8-pass 18x32
// multiply-accumulate and the output load. A stalled output adds its stall to the
// vertex behind it. s_tready is high only between requests. num_sides is written
// through cfg_wr_en/cfg_wr_data; the user is to write it only while idle, which
// the block itself does not enforce. Values below 3 are ignored.
`default_nettype none
`include "regular_polygon_vertex_generator_defines.svh"
module regular_polygon_vertex_generator (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_wr_en,
    input  wire logic [5:0]   cfg_wr_data,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [127:0] s_tdata,   // center_x, center_y, vertex_x, vertex_y
    input  wire logic         s_tuser,   // snap_square
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [63:0]       m_tdata,   // out_x, out_y
    output logic              m_tlast    // last_vertex
);
    import rpvg_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DIV    = 7'b0000010,
        S_FIRST  = 7'b0000100,
        S_PHASE  = 7'b0001000,
        S_CORDIC = 7'b0010000,
        S_MAC    = 7'b0100000,
        S_OUT    = 7'b1000000
    } state_t;

    state_t                 state_reg, state_next;
    logic [NUM_SIDES_W-1:0] sides_reg, sides_next;
    logic [NUM_SIDES_W-1:0] n_reg, n_next;
    logic [NUM_SIDES_W-1:0] i_reg, i_next;
    logic [NUM_SIDES_W-1:0] rem_reg, rem_next;
    logic [NUM_SIDES_W-1:0] acc_reg, acc_next;
    logic [5:0]             cnt_reg, cnt_next;
    logic [31:0]            quot_reg, quot_next;
    logic [31:0]            phase_reg, phase_next;
    logic signed [31:0]     cx_reg, cx_next, cy_reg, cy_next;
    logic signed [32:0]     dx_reg, dx_next, dy_reg, dy_next;
    logic                   cstart_reg, cstart_next;
    logic                   mstart_reg, mstart_next;
    logic                   mvalid_reg, mvalid_next;
    logic [31:0]            ox_reg, ox_next, oy_reg, oy_next;
    logic                   olast_reg, olast_next;

    logic                   in_fire, slot_free;
    logic signed [32:0]     dx_in, dy_in;
    logic [NUM_SIDES_W:0]   rem_ext, acc_sum;
    logic                   div_ge, wrap;
    logic                   cordic_done, mac_done;
    cs_t                    cs;
    logic signed [35:0]     rx, ry;

    rpvg_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cstart_reg),
        .phase   (phase_reg),
        .done    (cordic_done),
        .cs      (cs)
    );

    rpvg_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mstart_reg),
        .dx      (dx_reg),
        .dy      (dy_reg),
        .cs      (cs),
        .done    (mac_done),
        .rx      (rx),
        .ry      (ry)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign slot_free = !mvalid_reg || m_tready;

    assign dx_in = $signed({s_tdata[95], s_tdata[95:64]})
                 - $signed({s_tdata[31], s_tdata[31:0]});
    assign dy_in = $signed({s_tdata[127], s_tdata[127:96]})
                 - $signed({s_tdata[63], s_tdata[63:32]});

    // restoring division of 2^32 by n, one quotient bit a cycle
    assign rem_ext = {rem_reg, (cnt_reg == 6'd0)};
    assign div_ge  = rem_ext >= {1'b0, n_reg};
    // phase(i) = i*q + floor((i*r + n/2) / n), carried as a running remainder
    assign acc_sum = {1'b0, acc_reg} + {1'b0, rem_reg};
    assign wrap    = acc_sum >= {1'b0, n_reg};

    always_comb begin
        state_next  = state_reg;
        sides_next  = sides_reg;
        n_next      = n_reg;
        i_next      = i_reg;
        rem_next    = rem_reg;
        acc_next    = acc_reg;
        cnt_next    = cnt_reg;
        quot_next   = quot_reg;
        phase_next  = phase_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        dx_next     = dx_reg;
        dy_next     = dy_reg;
        cstart_next = 1'b0;
        mstart_next = 1'b0;
        ox_next     = ox_reg;
        oy_next     = oy_reg;
        olast_next  = olast_reg;
        mvalid_next = mvalid_reg && !m_tready;

        if (cfg_wr_en && cfg_wr_data >= NUM_SIDES_W'(MIN_SIDES)) begin
            sides_next = (cfg_wr_data > NUM_SIDES_W'(MAX_SIDES)) ? NUM_SIDES_W'(MAX_SIDES)
                                                                 : cfg_wr_data;
        end

        case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    cx_next  = $signed(s_tdata[31:0]);
                    cy_next  = $signed(s_tdata[63:32]);
                    dx_next  = dx_in;
                    dy_next  = dy_in;
                    if (s_tuser) begin
                        if (dy_in < dx_in) begin
                            dy_next = dx_in;
                        end else begin
                            dx_next = dy_in;
                        end
                    end
                    n_next     = sides_reg;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                rem_next  = div_ge ? NUM_SIDES_W'(rem_ext - {1'b0, n_reg})
                                   : rem_ext[NUM_SIDES_W-1:0];
                quot_next = {quot_reg[30:0], div_ge};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == 6'd32) begin
                    acc_next   = n_reg >> 1;
                    phase_next = '0;
                    i_next     = '0;
                    state_next = S_FIRST;
                end
            end
            S_FIRST: begin
                if (slot_free) begin
                    ox_next     = sat32(37'(cx_reg) + 37'(dx_reg));
                    oy_next     = sat32(37'(cy_reg) + 37'(dy_reg));
                    olast_next  = 1'b0;
                    mvalid_next = 1'b1;
                    state_next  = S_PHASE;
                end
            end
            S_PHASE: begin
                if (wrap) begin
                    acc_next   = NUM_SIDES_W'(acc_sum - {1'b0, n_reg});
                    phase_next = phase_reg + quot_reg + 32'd1;
                end else begin
                    acc_next   = acc_sum[NUM_SIDES_W-1:0];
                    phase_next = phase_reg + quot_reg;
                end
                i_next      = i_reg + 1'b1;
                cstart_next = 1'b1;
                state_next  = S_CORDIC;
            end
            S_CORDIC: begin
                if (cordic_done) begin
                    mstart_next = 1'b1;
                    state_next  = S_MAC;
                end
            end
            S_MAC: begin
                if (mac_done) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (slot_free) begin
                    ox_next     = sat32(37'(cx_reg) + 37'(rx));
                    oy_next     = sat32(37'(cy_reg) + 37'(ry));
                    olast_next  = (i_reg == n_reg);
                    mvalid_next = 1'b1;
                    state_next  = (i_reg == n_reg) ? S_IDLE : S_PHASE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            sides_reg  <= NUM_SIDES_W'(DEFAULT_SIDES);
            n_reg      <= NUM_SIDES_W'(DEFAULT_SIDES);
            i_reg      <= '0;
            cnt_reg    <= '0;
            cstart_reg <= 1'b0;
            mstart_reg <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            sides_reg  <= sides_next;
            n_reg      <= n_next;
            i_reg      <= i_next;
            cnt_reg    <= cnt_next;
            cstart_reg <= cstart_next;
            mstart_reg <= mstart_next;
            mvalid_reg <= mvalid_next;
        end
        rem_reg   <= rem_next;
        acc_reg   <= acc_next;
        quot_reg  <= quot_next;
        phase_reg <= phase_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        ox_reg    <= ox_next;
        oy_reg    <= oy_next;
        olast_reg <= olast_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {oy_reg, ox_reg};
    assign m_tlast  = olast_reg;

    `RPVG_ASSERT_NEXT(a_accept_starts_div, aclk, aresetn, in_fire,
        state_reg == S_DIV, "accepted request did not start the divider")
    `RPVG_ASSERT_NOW(a_vertex_count, aclk, aresetn,
        state_reg != S_IDLE && state_reg != S_DIV, i_reg <= n_reg,
        "vertex index ran past the side count")
    `RPVG_ASSERT_NOW(a_cordic_done_state, aclk, aresetn, cordic_done,
        state_reg == S_CORDIC, "CORDIC finished outside its state")
    `RPVG_ASSERT_NOW(a_mac_done_state, aclk, aresetn, mac_done,
        state_reg == S_MAC, "multiply pass finished outside its state")

endmodule
`default_nettype wire

### design/rpvg_cordic.sv
`default_nettype none
module rpvg_cordic (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         start,
    input  wire logic [31:0]  phase,
    output logic              done,
    output rpvg_pkg::cs_t     cs
);
    import rpvg_pkg::*;

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [STEP_W-1:0]  k_reg, k_next;
    logic [1:0]         quad_reg, quad_next;
    logic signed [33:0] x_reg, x_next, y_reg, y_next;
    logic signed [31:0] z_reg, z_next;
    logic signed [33:0] xs, ys;
    logic signed [31:0] xc, yc;

    function automatic logic signed [31:0] clamp30(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > ONE_Q30) begin
            r = ONE_Q30[31:0];
        end else if (v < -ONE_Q30) begin
            r = -ONE_Q30[31:0];
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    assign xs = x_reg >>> k_reg;
    assign ys = y_reg >>> k_reg;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        k_next    = k_reg;
        quad_next = quad_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        if (start) begin
            quad_next = phase[31:30];
            k_next    = '0;
            y_next    = '0;
            z_next    = $signed({2'b00, phase[29:0]});
            if (phase[29:0] == 30'd0) begin
                // exact angle, skip the iterations
                x_next    = ONE_Q30;
                done_next = 1'b1;
            end else begin
                x_next    = CORDIC_GAIN;
                busy_next = 1'b1;
            end
        end else if (busy_reg) begin
            if (!z_reg[31]) begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - atan_turns(k_reg);
            end else begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + atan_turns(k_reg);
            end
            k_next = k_reg + 1'b1;
            if (k_reg == STEP_W'(CORDIC_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            k_reg    <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            k_reg    <= k_next;
        end
        quad_reg <= quad_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
    end

    assign xc = clamp30(x_reg);
    assign yc = clamp30(y_reg);

    always_comb begin
        case (quad_reg)
            2'd0: begin cs.cos_q30 = xc;  cs.sin_q30 = yc;  end
            2'd1: begin cs.cos_q30 = -yc; cs.sin_q30 = xc;  end
            2'd2: begin cs.cos_q30 = -xc; cs.sin_q30 = -yc; end
            default: begin cs.cos_q30 = yc; cs.sin_q30 = -xc; end
        endcase
    end

    assign done = done_reg;

endmodule
`default_nettype wire

### design/rpvg_mac.sv
`default_nettype none
module rpvg_mac (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                start,
    input  wire logic signed [32:0]  dx,
    input  wire logic signed [32:0]  dy,
    input  wire rpvg_pkg::cs_t       cs,
    output logic                     done,
    output logic signed [35:0]       rx,
    output logic signed [35:0]       ry
);
    import rpvg_pkg::*;

    logic               issue_reg, issue_next;
    logic [2:0]         j_reg, j_next;
    logic               mvld_reg;
    logic [2:0]         tag_reg;
    logic               done_reg;
    logic signed [49:0] prod_reg;
    logic signed [65:0] accx_reg, accx_next, accy_reg, accy_next;
    logic signed [32:0] a_sel;
    logic signed [17:0] a_part;
    logic signed [31:0] b_sel;
    logic signed [65:0] term;
    logic signed [65:0] rnd_x, rnd_y;

    // j[2:1]: dx*cos, dy*sin, dx*sin, dy*cos; j[0]: low or high half of the offset
    assign a_sel  = j_reg[1] ? dy : dx;
    assign b_sel  = (j_reg[2] ^ j_reg[1]) ? cs.sin_q30 : cs.cos_q30;
    assign a_part = j_reg[0] ? $signed({a_sel[32], a_sel[32:16]})
                             : $signed({2'b00, a_sel[15:0]});

    assign term = tag_reg[0] ? (66'(prod_reg) <<< 16) : 66'(prod_reg);

    always_comb begin
        issue_next = issue_reg;
        j_next     = j_reg;
        accx_next  = accx_reg;
        accy_next  = accy_reg;
        if (start) begin
            issue_next = 1'b1;
            j_next     = '0;
            accx_next  = '0;
            accy_next  = '0;
        end else begin
            if (issue_reg) begin
                j_next = j_reg + 1'b1;
                if (j_reg == 3'd7) begin
                    issue_next = 1'b0;
                end
            end
            if (mvld_reg) begin
                case (tag_reg[2:1])
                    2'd0:    accx_next = accx_reg + term;
                    2'd1:    accx_next = accx_reg - term;
                    default: accy_next = accy_reg + term;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issue_reg <= 1'b0;
            mvld_reg  <= 1'b0;
            done_reg  <= 1'b0;
            j_reg     <= '0;
        end else begin
            issue_reg <= issue_next;
            mvld_reg  <= issue_reg && !start;
            done_reg  <= mvld_reg && tag_reg == 3'd7 && !start;
            j_reg     <= j_next;
        end
        tag_reg  <= j_reg;
        prod_reg <= a_part * b_sel;
        accx_reg <= accx_next;
        accy_reg <= accy_next;
    end

    assign rnd_x = (accx_reg + 66'sd536870912) >>> 30;
    assign rnd_y = (accy_reg + 66'sd536870912) >>> 30;
    assign rx    = rnd_x[35:0];
    assign ry    = rnd_y[35:0];
    assign done  = done_reg;

endmodule
`default_nettype wire
